>>> rtl/lgt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lgt_pkg;

  // Grid bound and derived widths
  localparam int MAX_SIZE = 64;
  localparam int IDX_W    = $clog2(MAX_SIZE);
  localparam int SIZE_W   = $clog2(MAX_SIZE + 1);
  localparam int CFG_W    = 7;

  localparam logic [CFG_W-1:0] GRID_SIZE_RST = CFG_W'(50);

  typedef logic [MAX_SIZE-1:0] row_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [SIZE_W-1:0]   size_t;
  typedef logic [1:0]          opcode_t;

  // Operation codes
  localparam opcode_t OP_WRITE = 2'd0;
  localparam opcode_t OP_READ  = 2'd1;
  localparam opcode_t OP_CLEAR = 2'd2;
  localparam opcode_t OP_STEP  = 2'd3;

  // Broadcast control from the sequencer to every row cell
  typedef struct packed {
    logic  shift;     // ring rotates by one row
    row_t  tail_row;  // value entering the last active cell
    logic  zero_en;   // cell 0 takes zero_row instead of its neighbor
    row_t  zero_row;
    logic  pen_en;    // second-to-last active cell takes pen_row
    row_t  pen_row;
    logic  clear;
    row_t  col_mask;  // active columns
    logic  wr_en;
    idx_t  wr_row;
    idx_t  wr_col;
    logic  wr_val;
    size_t n;         // active side length
  } lgt_cell_ctl_t;

  // One generation for a whole row, columns wrapped at n.
  // Columns at or beyond n keep their current value.
  function automatic row_t life_row(row_t up, row_t cur, row_t dn, size_t n);
    row_t       res;
    idx_t       last;
    idx_t       lc;
    idx_t       rc;
    logic [3:0] cnt;
    last = IDX_W'(n - SIZE_W'(1));
    for (int c = 0; c < MAX_SIZE; c++) begin
      lc  = (c == 0) ? last : IDX_W'(c - 1);
      rc  = (c + 1 >= int'(n)) ? '0 : IDX_W'(c + 1);
      cnt = 4'(up[lc]) + 4'(up[c]) + 4'(up[rc]) + 4'(cur[lc]) + 4'(cur[rc])
          + 4'(dn[lc]) + 4'(dn[c]) + 4'(dn[rc]);
      if (c < int'(n)) begin
        res[c] = (cnt == 4'd3) || ((cnt == 4'd2) && cur[c]);
      end else begin
        res[c] = cur[c];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/lgt_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Command channel
interface lgt_in_if;
  logic            valid;
  logic            ready;
  lgt_pkg::opcode_t opcode;
  lgt_pkg::idx_t   row;
  lgt_pkg::idx_t   column;
  logic            cell_value;

  modport source (output valid, opcode, row, column, cell_value, input ready);
  modport sink   (input valid, opcode, row, column, cell_value, output ready);
endinterface

// Result channel
interface lgt_out_if;
  logic valid;
  logic ready;
  logic read_value;
  logic stable;

  modport source (output valid, read_value, stable, input ready);
  modport sink   (input valid, read_value, stable, output ready);
endinterface

`default_nettype wire

>>> rtl/life_generation_torus.sv
`timescale 1ns / 1ps
`default_nettype none

// Write and clear pass from the transfer through the finish state into the result register;
//   read and generation step first rotate the n = min(grid_size, 64) active rows (not when n is 0).
// A new command is taken only when idle, after the last result is loaded; loading waits while
//   an earlier result is unread. The grid is a ring of row cells that rotates one row
//   per cycle through the rule logic.
// Reset: grid all dead, grid_size 50, no result pending.
module life_generation_torus (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [lgt_pkg::CFG_W-1:0]   cfg_wdata,
  lgt_in_if.sink                           req,
  lgt_out_if.source                        rsp
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PASS   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                 state;
  logic [lgt_pkg::CFG_W-1:0]  grid_size;
  lgt_pkg::size_t             n;
  lgt_pkg::size_t             cnt;
  lgt_pkg::opcode_t           op;
  lgt_pkg::idx_t              row_q;
  lgt_pkg::idx_t              col_q;
  logic                       changed;
  logic                       rd;
  logic                       out_valid;
  logic                       out_read;
  logic                       out_stable;
  lgt_pkg::row_t              prev;
  lgt_pkg::row_t              prev2;
  lgt_pkg::row_t              first;
  lgt_pkg::row_t              second;

  lgt_pkg::row_t              rows [lgt_pkg::MAX_SIZE];
  lgt_pkg::row_t              head;
  lgt_pkg::row_t              first_eff;
  lgt_pkg::row_t              row_nm2;
  lgt_pkg::row_t              row_one;
  lgt_pkg::row_t              pen_new;
  lgt_pkg::row_t              tail_new;
  lgt_pkg::row_t              zero_new;
  lgt_pkg::row_t              mask;
  lgt_pkg::lgt_cell_ctl_t     ctl;
  logic                       accept;
  logic                       is_step;
  logic                       last;
  logic                       diff;
  logic                       load_out;

  // Active size, saturated at the grid bound
  assign n = (grid_size > lgt_pkg::CFG_W'(lgt_pkg::MAX_SIZE)) ?
             lgt_pkg::SIZE_W'(lgt_pkg::MAX_SIZE) : lgt_pkg::SIZE_W'(grid_size);

  assign accept         = req.valid && req.ready;
  assign req.ready      = (state == ST_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_read;
  assign rsp.stable     = out_stable;

  // Result register loads once the previous result is gone or leaves now
  assign load_out = (state == ST_FINISH) && (!out_valid || rsp.ready);

  always_comb begin
    for (int c = 0; c < lgt_pkg::MAX_SIZE; c++) begin
      mask[c] = c < int'(n);
    end
  end

  // Row taps: head is the row at cell 0; originals of the wrap rows are kept aside
  assign head      = rows[0];
  assign is_step   = (op == lgt_pkg::OP_STEP);
  assign last      = (cnt == (n - lgt_pkg::SIZE_W'(1)));
  assign first_eff = (cnt == '0) ? head : first;
  assign row_nm2   = (n == lgt_pkg::SIZE_W'(1)) ? head : prev;
  assign row_one   = (n <= lgt_pkg::SIZE_W'(2)) ? head : second;

  assign pen_new  = lgt_pkg::life_row(prev2, prev, head, n);
  assign tail_new = lgt_pkg::life_row(row_nm2, head, first_eff, n);
  assign zero_new = lgt_pkg::life_row(head, first_eff, row_one, n);

  // Cell control
  always_comb begin
    ctl.shift    = (state == ST_PASS);
    ctl.zero_en  = is_step && last;
    ctl.tail_row = ctl.zero_en ? tail_new : head;
    ctl.zero_row = zero_new;
    ctl.pen_en   = is_step && (cnt >= lgt_pkg::SIZE_W'(2));
    ctl.pen_row  = pen_new;
    ctl.clear    = accept && (req.opcode == lgt_pkg::OP_CLEAR);
    ctl.col_mask = mask;
    ctl.wr_en    = accept && (req.opcode == lgt_pkg::OP_WRITE) &&
                   (lgt_pkg::SIZE_W'(req.row) < n) && (lgt_pkg::SIZE_W'(req.column) < n);
    ctl.wr_row   = req.row;
    ctl.wr_col   = req.column;
    ctl.wr_val   = req.cell_value;
    ctl.n        = n;
  end

  assign diff = (ctl.pen_en && (pen_new != prev)) ||
                (ctl.zero_en && ((tail_new != head) || (zero_new != first_eff)));

  // Ring of row cells
  for (genvar i = 0; i < lgt_pkg::MAX_SIZE; i++) begin : g_cell
    lgt_row_cell u_cell (
      .clk (clk),
      .rst (rst),
      .idx (lgt_pkg::IDX_W'(i)),
      .nbr (rows[(i + 1) % lgt_pkg::MAX_SIZE]),
      .ctl (ctl),
      .row (rows[i])
    );
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      grid_size <= lgt_pkg::GRID_SIZE_RST;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (cfg_we) begin
        grid_size <= cfg_wdata;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cnt <= '0;
            if (((req.opcode == lgt_pkg::OP_READ) || (req.opcode == lgt_pkg::OP_STEP)) &&
                (n != '0)) begin
              state <= ST_PASS;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_PASS: begin
          cnt <= cnt + lgt_pkg::SIZE_W'(1);
          if (last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= req.opcode;
      row_q   <= req.row;
      col_q   <= req.column;
      changed <= 1'b0;
      rd      <= 1'b0;
    end
    if (state == ST_PASS) begin
      prev  <= head;
      prev2 <= prev;
      if (cnt == '0) begin
        first <= head;
      end
      if (cnt == lgt_pkg::SIZE_W'(1)) begin
        second <= head;
      end
      if (is_step && diff) begin
        changed <= 1'b1;
      end
      if ((op == lgt_pkg::OP_READ) && (cnt == lgt_pkg::SIZE_W'(row_q)) &&
          (lgt_pkg::SIZE_W'(col_q) < n)) begin
        rd <= head[col_q];
      end
    end
    if (load_out) begin
      out_read   <= (op == lgt_pkg::OP_READ) && rd;
      out_stable <= is_step && !changed;
    end
  end

`ifndef SYNTHESIS
  // The row counter never runs past the active ring
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PASS) |-> (cnt < n))
    else $error("row counter beyond active size");

  // A transfer always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("accepted item left the block idle");

  // A new result appears only out of the finish state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> ($past(state) == ST_FINISH))
    else $error("result raised outside finish");

  // Rule taps are only used during a generation pass
  a_taps_step: assert property (@(posedge clk) disable iff (rst)
    (ctl.shift && (ctl.pen_en || ctl.zero_en)) |-> is_step)
    else $error("update taps active during a read pass");
`endif

endmodule

`default_nettype wire

>>> rtl/lgt_row_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One grid row of the rotating ring; takes the row of the next-higher cell index on a shift
module lgt_row_cell (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire lgt_pkg::idx_t          idx,
  input  wire lgt_pkg::row_t          nbr,
  input  wire lgt_pkg::lgt_cell_ctl_t ctl,
  output lgt_pkg::row_t               row
);

  lgt_pkg::size_t pos;
  logic           active;
  logic           is_tail;
  logic           is_pen;
  lgt_pkg::row_t  row_next;

  assign pos     = lgt_pkg::SIZE_W'(idx);
  assign active  = pos < ctl.n;
  assign is_tail = (pos + lgt_pkg::SIZE_W'(1)) == ctl.n;
  assign is_pen  = (pos + lgt_pkg::SIZE_W'(2)) == ctl.n;

  // Next row: clear, single-cell write, or ring shift with update taps
  always_comb begin
    row_next = row;
    priority if (ctl.clear && active) begin
      row_next = row & ~ctl.col_mask;
    end else if (ctl.wr_en && (ctl.wr_row == idx)) begin
      row_next[ctl.wr_col] = ctl.wr_val;
    end else if (ctl.shift && active) begin
      priority if (is_tail) begin
        row_next = ctl.tail_row;
      end else if (ctl.zero_en && (idx == '0)) begin
        row_next = ctl.zero_row;
      end else if (ctl.pen_en && is_pen) begin
        row_next = ctl.pen_row;
      end else begin
        row_next = nbr;
      end
    end else begin
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else begin
      row <= row_next;
    end
  end

endmodule

`default_nettype wire

>>> sim/lgt_checker.sv
`timescale 1ns / 1ps

// Watches the command and result channels, keeps its own copy of the Life grid
// and compares every result transfer with the oldest prediction.
module lgt_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [lgt_pkg::CFG_W-1:0] cfg_wdata,
  lgt_in_if                         req,
  lgt_out_if                        rsp,
  output int                        fail_count,
  output int                        outstanding
);

  typedef struct packed {
    logic read_value;
    logic stable;
  } life_rsp_t;

  // Shadow of the grid and the side-length register
  lgt_pkg::row_t             board [lgt_pkg::MAX_SIZE];
  logic [lgt_pkg::CFG_W-1:0] board_size;
  life_rsp_t                 rsp_q [$];
  life_rsp_t                 want;

  // Side length in use, bounded by the grid allocation
  function automatic int active_side();
    return (int'(board_size) > lgt_pkg::MAX_SIZE) ? lgt_pkg::MAX_SIZE : int'(board_size);
  endfunction

  // B3/S23 rule for one cell, all eight neighbors wrapped at n
  function automatic logic next_cell(int r, int c, int n);
    int up;
    int dn;
    int lf;
    int rt;
    int cnt;
    up  = (r == 0) ? n - 1 : r - 1;
    dn  = (r + 1 >= n) ? 0 : r + 1;
    lf  = (c == 0) ? n - 1 : c - 1;
    rt  = (c + 1 >= n) ? 0 : c + 1;
    cnt = int'(board[up][lf]) + int'(board[up][c]) + int'(board[up][rt])
        + int'(board[r][lf]) + int'(board[r][rt])
        + int'(board[dn][lf]) + int'(board[dn][c]) + int'(board[dn][rt]);
    return (cnt == 3) || ((cnt == 2) && board[r][c]);
  endfunction

  // One generation over the active square; returns 1 when nothing changed
  function automatic logic advance_board();
    lgt_pkg::row_t nxt [lgt_pkg::MAX_SIZE];
    int            n;
    logic          changed;
    n       = active_side();
    changed = 1'b0;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        nxt[i][j] = next_cell(i, j, n);
        if (nxt[i][j] != board[i][j]) changed = 1'b1;
      end
    end
    if (!changed) return 1'b1;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) board[i][j] = nxt[i][j];
    end
    return 1'b0;
  endfunction

  // Apply one command to the shadow grid and build its result
  function automatic life_rsp_t apply_command(lgt_pkg::opcode_t op, lgt_pkg::idx_t r,
                                              lgt_pkg::idx_t c, logic v);
    life_rsp_t res;
    int        n;
    res = '0;
    n   = active_side();
    case (op)
      lgt_pkg::OP_WRITE: begin
        if (int'(r) < n && int'(c) < n) board[r][c] = v;
      end
      lgt_pkg::OP_READ: begin
        if (int'(r) < n && int'(c) < n) res.read_value = board[r][c];
      end
      lgt_pkg::OP_CLEAR: begin
        for (int i = 0; i < n; i++) begin
          for (int j = 0; j < n; j++) board[i][j] = 1'b0;
        end
      end
      default: begin
        res.stable = advance_board();
      end
    endcase
    return res;
  endfunction

  // Results are matched before the new command is taken in, since a result
  // never leaves in the cycle of its own command transfer.
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lgt_pkg::MAX_SIZE; i++) board[i] = '0;
      board_size = lgt_pkg::GRID_SIZE_RST;
      fail_count = 0;
      rsp_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (rsp_q.size() == 0) begin
          $error("result transfer with no command outstanding");
          fail_count++;
        end else begin
          want = rsp_q.pop_front();
          if (rsp.read_value !== want.read_value) begin
            $error("read_value mismatch: expected %0b, actual %0b",
                   want.read_value, rsp.read_value);
            fail_count++;
          end
          if (rsp.stable !== want.stable) begin
            $error("stable mismatch: expected %0b, actual %0b",
                   want.stable, rsp.stable);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        rsp_q.push_back(apply_command(req.opcode, req.row, req.column, req.cell_value));
      end
      if (cfg_we) board_size = cfg_wdata;
    end
    outstanding = rsp_q.size();
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 110;
  localparam int DRAIN_CYC   = 70;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [lgt_pkg::CFG_W-1:0] cfg_wdata;
  int                        fail_count;
  int                        outstanding;
  bit                        quiet;
  int                        cur_n;

  lgt_in_if  req_if ();
  lgt_out_if rsp_if ();

  always #5 clk = ~clk;

  life_generation_torus u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  lgt_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req         (req_if),
    .rsp         (rsp_if),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Result side back-pressure
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_if.ready = quiet ? 1'b1 : ($urandom_range(99) >= 9);
    end
  end

  // One command transfer; called at a falling edge, returns at a falling edge
  task automatic send_cmd(lgt_pkg::opcode_t op, lgt_pkg::idx_t r, lgt_pkg::idx_t c,
                          logic v);
    while (!quiet && $urandom_range(99) < 9) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid      = 1'b1;
    req_if.opcode     = op;
    req_if.row        = r;
    req_if.column     = c;
    req_if.cell_value = v;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off the command side until every result has come back
  task automatic wait_results();
    req_if.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Register write with the block idle
  task automatic set_size(int sz);
    wait_results();
    repeat (DRAIN_CYC) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = lgt_pkg::CFG_W'(sz);
    cur_n     = sz;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Random command biased toward cells inside the active square
  task automatic random_cmd();
    int               pick;
    int               lim;
    lgt_pkg::opcode_t op;
    lgt_pkg::idx_t    r;
    lgt_pkg::idx_t    c;
    logic             v;
    pick = $urandom_range(99);
    if (pick < 45)      op = lgt_pkg::OP_WRITE;
    else if (pick < 75) op = lgt_pkg::OP_READ;
    else if (pick < 96) op = lgt_pkg::OP_STEP;
    else                op = lgt_pkg::OP_CLEAR;
    lim = (cur_n > lgt_pkg::MAX_SIZE) ? lgt_pkg::MAX_SIZE - 1 :
          ((cur_n == 0) ? 0 : cur_n - 1);
    if ($urandom_range(99) < 85) begin
      r = lgt_pkg::idx_t'($urandom_range(lim));
      c = lgt_pkg::idx_t'($urandom_range(lim));
    end else begin
      r = lgt_pkg::idx_t'($urandom);
      c = lgt_pkg::idx_t'($urandom);
    end
    v = ($urandom_range(99) < 60);
    send_cmd(op, r, c, v);
  endtask

  // Stimulus
  initial begin
    int sizes [10];
    int sz;
    int lim;
    int r0;
    int c0;
    sizes             = '{3, 64, 0, 1, 2, 127, 65, 8, 50, 16};
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    quiet             = 1'b0;
    cur_n             = 50;
    req_if.valid      = 1'b0;
    req_if.opcode     = lgt_pkg::OP_WRITE;
    req_if.row        = '0;
    req_if.column     = '0;
    req_if.cell_value = 1'b0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Directed: default size, reads inside and outside, single cell dying
    send_cmd(lgt_pkg::OP_READ, 6'd0, 6'd0, 1'b0);
    send_cmd(lgt_pkg::OP_WRITE, 6'd0, 6'd0, 1'b1);
    send_cmd(lgt_pkg::OP_READ, 6'd0, 6'd0, 1'b0);
    send_cmd(lgt_pkg::OP_WRITE, 6'd63, 6'd63, 1'b1);
    send_cmd(lgt_pkg::OP_READ, 6'd63, 6'd63, 1'b0);
    send_cmd(lgt_pkg::OP_STEP, 6'd0, 6'd0, 1'b0);
    send_cmd(lgt_pkg::OP_STEP, 6'd0, 6'd0, 1'b0);
    // blinker straddling the column wrap, then the row wrap
    send_cmd(lgt_pkg::OP_WRITE, 6'd0, 6'd49, 1'b1);
    send_cmd(lgt_pkg::OP_WRITE, 6'd0, 6'd0, 1'b1);
    send_cmd(lgt_pkg::OP_WRITE, 6'd0, 6'd1, 1'b1);
    send_cmd(lgt_pkg::OP_STEP, 6'd0, 6'd0, 1'b0);
    send_cmd(lgt_pkg::OP_READ, 6'd49, 6'd0, 1'b0);
    send_cmd(lgt_pkg::OP_READ, 6'd0, 6'd49, 1'b0);
    send_cmd(lgt_pkg::OP_STEP, 6'd0, 6'd0, 1'b0);
    send_cmd(lgt_pkg::OP_CLEAR, 6'd0, 6'd0, 1'b0);
    send_cmd(lgt_pkg::OP_READ, 6'd0, 6'd1, 1'b0);

    // Full size corner, then cells outside a shrunken square survive
    set_size(lgt_pkg::MAX_SIZE);
    send_cmd(lgt_pkg::OP_WRITE, 6'd63, 6'd63, 1'b1);
    send_cmd(lgt_pkg::OP_READ, 6'd63, 6'd63, 1'b0);
    send_cmd(lgt_pkg::OP_WRITE, 6'd60, 6'd2, 1'b1);
    set_size(8);
    send_cmd(lgt_pkg::OP_CLEAR, 6'd0, 6'd0, 1'b0);
    send_cmd(lgt_pkg::OP_STEP, 6'd0, 6'd0, 1'b0);
    send_cmd(lgt_pkg::OP_READ, 6'd60, 6'd2, 1'b0);
    set_size(lgt_pkg::MAX_SIZE);
    send_cmd(lgt_pkg::OP_READ, 6'd60, 6'd2, 1'b0);
    send_cmd(lgt_pkg::OP_CLEAR, 6'd0, 6'd0, 1'b0);

    // Random phases, each under its own grid size
    for (int p = 0; p < PHASES; p++) begin
      sz = (p < 10) ? sizes[p] : $urandom_range(64, 3);
      set_size(sz);
      quiet = (p == 8);
      // seed a dense patch so the generations have something to work on
      lim = (cur_n > lgt_pkg::MAX_SIZE) ? lgt_pkg::MAX_SIZE : ((cur_n == 0) ? 1 : cur_n);
      r0  = $urandom_range(lim - 1);
      c0  = $urandom_range(lim - 1);
      for (int k = 0; k < 20; k++) begin
        send_cmd(lgt_pkg::OP_WRITE, lgt_pkg::idx_t'((r0 + $urandom_range(4)) % lim),
                 lgt_pkg::idx_t'((c0 + $urandom_range(4)) % lim), $urandom_range(99) < 55);
      end
      for (int k = 20; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(99) == 0) wait_results();
        random_cmd();
      end
      quiet = 1'b0;
    end

    // Drain and verdict
    wait_results();
    repeat (DRAIN_CYC) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit
  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
rtl/lgt_pkg.sv
rtl/lgt_if.sv
rtl/lgt_row_cell.sv
rtl/life_generation_torus.sv
sim/lgt_checker.sv
sim/tb.sv
